// ----- rtl/nfa_sc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nfa_sc_pkg;

    // Default sizes of the automaton.
    localparam int NFA_STATES_DEF = 8;
    localparam int SYMBOLS_DEF    = 16;

    // Fixed field widths on the ports.
    localparam int CMD_W      = 2;
    localparam int STATE_W    = 3;
    localparam int SYMBOL_W   = 4;
    localparam int SET_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Command codes carried by an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_SYM = 2'd0,
        CMD_ADD_EPS = 2'd1,
        CMD_QUERY   = 2'd2
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE = 1'b0,
        CFG_ACCEPT_MASK = 1'b1
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_GATHER,
        ST_CLOSE,
        ST_DONE
    } fsm_t;

endpackage

`default_nettype wire

// ----- rtl/nfa_sc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nfa_sc_ram #(
    parameter int WIDTH = nfa_sc_pkg::NFA_STATES_DEF,
    parameter int DEPTH = nfa_sc_pkg::NFA_STATES_DEF * nfa_sc_pkg::SYMBOLS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nfa_subset_transition_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Subset-construction step engine for an NFA of NFA_STATES states over SYMBOLS
// symbols. Symbol transitions live in a single-port-read, single-port-write RAM
// of NFA_STATES*SYMBOLS rows (one next-state mask per state and symbol); epsilon
// transitions live in a small flop table. After reset the RAM is swept clear, one
// row per cycle, and no item is accepted meanwhile; configuration writes are
// taken at any time. An epsilon add is written straight into the flop table;
// a symbol add reads the row, then writes it back with the new bit. A query
// reads one RAM row per NFA state through the one read port (skipped when the
// symbol is out of range), then runs NFA_STATES closure rounds over the epsilon
// table, then loads the output register once it is free. The engine handles
// one item at a time; a finished result waits in the output register while
// the next item is taken. DFA states are subset bitmasks and the empty set is
// the dead state.
module nfa_subset_transition_engine #(
    parameter int NFA_STATES = nfa_sc_pkg::NFA_STATES_DEF,
    parameter int SYMBOLS    = nfa_sc_pkg::SYMBOLS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [nfa_sc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nfa_sc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input item channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [nfa_sc_pkg::CMD_W-1:0]        command,
    input  wire logic [nfa_sc_pkg::STATE_W-1:0]      nfa_state,
    input  wire logic [nfa_sc_pkg::SYMBOL_W-1:0]     symbol,
    input  wire logic [nfa_sc_pkg::STATE_W-1:0]      target_state,
    input  wire logic [nfa_sc_pkg::SET_W-1:0]        state_set,
    // Result item channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [nfa_sc_pkg::SET_W-1:0]        next_set,
    output logic                                     next_accepts,
    output logic                                     from_accepts,
    output logic      [nfa_sc_pkg::SET_W-1:0]        start_set
);

    localparam int W     = NFA_STATES;
    localparam int DEPTH = NFA_STATES * SYMBOLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (W > 1) ? $clog2(W) : 1;
    localparam int SET_W = nfa_sc_pkg::SET_W;
    localparam int ST_W  = nfa_sc_pkg::STATE_W;

    nfa_sc_pkg::fsm_t state_reg, state_next;

    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [RW-1:0]    round_reg, round_next;
    logic [W-1:0]     query_reg, query_next;
    logic [W-1:0]     cur_reg, cur_next;
    logic [W-1:0]     start_cur_reg, start_cur_next;
    logic [W-1:0]     bit_reg, bit_next;
    logic             from_acc_reg, from_acc_next;
    logic [W-1:0]     eps_reg [W];

    logic [ST_W-1:0]  start_state_reg;
    logic [SET_W-1:0] accept_mask_reg;

    logic             out_valid_reg;
    logic [SET_W-1:0] next_set_reg;
    logic             next_acc_reg;
    logic             from_out_reg;
    logic [SET_W-1:0] start_set_reg;

    // RAM port signals
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [W-1:0]     rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [W-1:0]     wr_data;

    // Decoded input item
    logic               in_fire;
    logic               out_free;
    logic               src_ok, dst_ok, sym_ok;
    logic [31:0]        in_addr_full;
    logic [31:0]        sym_addr_full;
    logic [AW-1:0]      in_addr;
    logic [AW-1:0]      sym_addr;
    logic [AW-1:0]      addr_step;
    logic [RW+ST_W-1:0] src_pad;
    logic [RW-1:0]      src_idx;
    logic [W+SET_W-1:0] set_pad;
    logic [W-1:0]       in_set;
    logic [W+SET_W-1:0] acc_pad;
    logic [W-1:0]       acc_set;
    logic [W-1:0]       dst_onehot;
    logic [W-1:0]       start_onehot;
    logic [W-1:0]       row_data;
    logic [W-1:0]       cur_grow;
    logic [W-1:0]       start_grow;
    logic [W+SET_W-1:0] cur_pad;
    logic [W+SET_W-1:0] start_pad;

    // Symbol transition table.
    nfa_sc_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_sym_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != nfa_sc_pkg::ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Range checks and address of the input item.
    assign src_ok        = int'(nfa_state) < W;
    assign dst_ok        = int'(target_state) < W;
    assign sym_ok        = int'(symbol) < SYMBOLS;
    assign in_addr_full  = 32'(nfa_state) * 32'(SYMBOLS) + 32'(symbol);
    assign sym_addr_full = 32'(symbol);
    assign in_addr       = in_addr_full[AW-1:0];
    assign sym_addr      = sym_addr_full[AW-1:0];
    assign addr_step     = addr_reg + AW'(SYMBOLS);
    assign src_pad       = {{RW{1'b0}}, nfa_state};
    assign src_idx       = src_pad[RW-1:0];

    // Bits at or above NFA_STATES are dropped from the sets.
    assign set_pad = {{W{1'b0}}, state_set};
    assign in_set  = set_pad[W-1:0];
    assign acc_pad = {{W{1'b0}}, accept_mask_reg};
    assign acc_set = acc_pad[W-1:0];

    // One-hot decode of the target and start states.
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            dst_onehot[i]   = (int'(target_state) == i);
            start_onehot[i] = (int'(start_state_reg) == i);
        end
    end

    // One closure round for the successor and for the start set.
    always_comb
    begin
        cur_grow   = cur_reg;
        start_grow = start_cur_reg;
        for (int s = 0; s < W; s++)
        begin
            if (cur_reg[s])
            begin
                cur_grow = cur_grow | eps_reg[s];
            end
            if (start_cur_reg[s])
            begin
                start_grow = start_grow | eps_reg[s];
            end
        end
    end

    // The row just read counts only if its state is in the queried subset.
    assign row_data = query_reg[row_reg] ? rd_data : '0;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfa_sc_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = nfa_sc_pkg::ST_IDLE;
                end
            end
            nfa_sc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == nfa_sc_pkg::CMD_ADD_SYM)
                    begin
                        if (src_ok && dst_ok && sym_ok)
                        begin
                            state_next = nfa_sc_pkg::ST_ADD;
                        end
                    end
                    else if (command == nfa_sc_pkg::CMD_QUERY)
                    begin
                        state_next = sym_ok ? nfa_sc_pkg::ST_GATHER : nfa_sc_pkg::ST_CLOSE;
                    end
                end
            end
            nfa_sc_pkg::ST_ADD:
            begin
                state_next = nfa_sc_pkg::ST_IDLE;
            end
            nfa_sc_pkg::ST_GATHER:
            begin
                if (row_reg == RW'(W - 1))
                begin
                    state_next = nfa_sc_pkg::ST_CLOSE;
                end
            end
            nfa_sc_pkg::ST_CLOSE:
            begin
                if (round_reg == RW'(W - 1))
                begin
                    state_next = nfa_sc_pkg::ST_DONE;
                end
            end
            nfa_sc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = nfa_sc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfa_sc_pkg::ST_IDLE;
            end
        endcase
    end

    // RAM port control.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = addr_step;
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = rd_data | bit_reg;
        case (state_reg)
            nfa_sc_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            nfa_sc_pkg::ST_IDLE:
            begin
                rd_en   = in_fire;
                rd_addr = (command == nfa_sc_pkg::CMD_QUERY) ? sym_addr : in_addr;
            end
            nfa_sc_pkg::ST_ADD:
            begin
                wr_en = 1'b1;
            end
            nfa_sc_pkg::ST_GATHER:
            begin
                rd_en = (row_reg != RW'(W - 1));
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        addr_next      = addr_reg;
        row_next       = row_reg;
        round_next     = round_reg;
        query_next     = query_reg;
        cur_next       = cur_reg;
        start_cur_next = start_cur_reg;
        bit_next       = bit_reg;
        from_acc_next  = from_acc_reg;
        case (state_reg)
            nfa_sc_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            nfa_sc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == nfa_sc_pkg::CMD_QUERY)
                    begin
                        addr_next      = sym_addr;
                        query_next     = in_set;
                        from_acc_next  = |(in_set & acc_set);
                        cur_next       = '0;
                        start_cur_next = start_onehot;
                        row_next       = '0;
                        round_next     = '0;
                    end
                    else
                    begin
                        addr_next = in_addr;
                        bit_next  = dst_onehot;
                    end
                end
            end
            nfa_sc_pkg::ST_GATHER:
            begin
                cur_next  = cur_reg | row_data;
                row_next  = row_reg + 1'b1;
                addr_next = addr_step;
            end
            nfa_sc_pkg::ST_CLOSE:
            begin
                cur_next       = cur_grow;
                start_cur_next = start_grow;
                round_next     = round_reg + 1'b1;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // Sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nfa_sc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        row_reg       <= row_next;
        round_reg     <= round_next;
        query_reg     <= query_next;
        cur_reg       <= cur_next;
        start_cur_reg <= start_cur_next;
        bit_reg       <= bit_next;
        from_acc_reg  <= from_acc_next;
    end

    // Epsilon table, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < W; i++)
            begin
                eps_reg[i] <= '0;
            end
        end
        else if (in_fire && (command == nfa_sc_pkg::CMD_ADD_EPS) && src_ok && dst_ok)
        begin
            eps_reg[src_idx] <= eps_reg[src_idx] | dst_onehot;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            accept_mask_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nfa_sc_pkg::CFG_START_STATE: start_state_reg <= cfg_data[ST_W-1:0];
                nfa_sc_pkg::CFG_ACCEPT_MASK: accept_mask_reg <= cfg_data[SET_W-1:0];
                default:                     start_state_reg <= start_state_reg;
            endcase
        end
    end

    // Result register, loaded when the query completes and the slot is free.
    assign cur_pad   = {{SET_W{1'b0}}, cur_reg};
    assign start_pad = {{SET_W{1'b0}}, start_cur_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == nfa_sc_pkg::ST_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == nfa_sc_pkg::ST_DONE) && out_free)
        begin
            next_set_reg  <= cur_pad[SET_W-1:0];
            next_acc_reg  <= |(cur_reg & acc_set);
            from_out_reg  <= from_acc_reg;
            start_set_reg <= start_pad[SET_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_set     = next_set_reg;
    assign next_accepts = next_acc_reg;
    assign from_accepts = from_out_reg;
    assign start_set    = start_set_reg;

endmodule

`default_nettype wire

// ----- rtl/nfa_sc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nfa_sc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [nfa_sc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [nfa_sc_pkg::CFG_DATA_W-1:0] cfg_data,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic [nfa_sc_pkg::CMD_W-1:0]      command,
    input wire logic [nfa_sc_pkg::STATE_W-1:0]    nfa_state,
    input wire logic [nfa_sc_pkg::SYMBOL_W-1:0]   symbol,
    input wire logic [nfa_sc_pkg::STATE_W-1:0]    target_state,
    input wire logic [nfa_sc_pkg::SET_W-1:0]      state_set,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [nfa_sc_pkg::SET_W-1:0]      next_set,
    input wire logic                              next_accepts,
    input wire logic                              from_accepts,
    input wire logic [nfa_sc_pkg::SET_W-1:0]      start_set
);

    // A stalled result stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_set) &&
        $stable(next_accepts) && $stable(from_accepts) && $stable(start_set))
        else $error("stalled result item changed");

    // An add item never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid &&
        (command == nfa_sc_pkg::CMD_ADD_SYM || command == nfa_sc_pkg::CMD_ADD_EPS)
        |=> !out_valid)
        else $error("result item appeared after an add item");

    // A query keeps the engine busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == nfa_sc_pkg::CMD_QUERY) |=> in_stall)
        else $error("item accepted while a query was in progress");

    // The configuration port never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind nfa_subset_transition_engine nfa_sc_checker u_nfa_sc_checker (.*);

`default_nettype wire
